/* hdl/nnsa_pkg.sv */
// Package for the nearest-neighbour scaler address generator.
// Holds the shared types, register map, status codes and pipeline constants.
// No dependencies.
`default_nettype none
package nnsa_pkg;

	localparam int MAX_DIMENSION_DEF = 8192;

	localparam int DIM_W  = 14;
	localparam int POS_W  = 13;
	localparam int PROD_W = 2 * DIM_W;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES = DIM_W / DIV_STEPS_PER_STAGE;
	// front stages, divider stages, output register
	localparam int PIPE_LATENCY = 2 + DIV_STAGES + 1;

	localparam logic [2:0] REG_SOURCE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_SOURCE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd2;
	localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd3;
	localparam logic [2:0] REG_VIEW_LEFT      = 3'd4;
	localparam logic [2:0] REG_VIEW_TOP       = 3'd5;
	localparam logic [2:0] REG_VIEW_WIDTH     = 3'd6;
	localparam logic [2:0] REG_VIEW_HEIGHT    = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CONFIG  = 2'd1;
	localparam logic [1:0] ST_REQUEST = 2'd2;
	localparam logic [1:0] ST_OUTSIDE = 2'd3;

	typedef struct packed {
		logic [DIM_W-1:0] source_width;
		logic [DIM_W-1:0] source_height;
		logic [DIM_W-1:0] surface_width;
		logic [DIM_W-1:0] surface_height;
		logic [POS_W-1:0] view_left;
		logic [POS_W-1:0] view_top;
		logic [DIM_W-1:0] view_width;
		logic [DIM_W-1:0] view_height;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] tile_left;
		logic [POS_W-1:0] tile_top;
		logic [DIM_W-1:0] tile_cols;
		logic [DIM_W-1:0] tile_rows;
	} side_t;

endpackage
`default_nettype wire

/* hdl/nnsa_regs.sv */
// Configuration register file behind the APB-style port.
// Depends on nnsa_pkg.
`default_nettype none
module nnsa_regs
	import nnsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_SOURCE_WIDTH:   cfg_q.source_width   <= pwdata[DIM_W-1:0];
				REG_SOURCE_HEIGHT:  cfg_q.source_height  <= pwdata[DIM_W-1:0];
				REG_SURFACE_WIDTH:  cfg_q.surface_width  <= pwdata[DIM_W-1:0];
				REG_SURFACE_HEIGHT: cfg_q.surface_height <= pwdata[DIM_W-1:0];
				REG_VIEW_LEFT:      cfg_q.view_left      <= pwdata[POS_W-1:0];
				REG_VIEW_TOP:       cfg_q.view_top       <= pwdata[POS_W-1:0];
				REG_VIEW_WIDTH:     cfg_q.view_width     <= pwdata[DIM_W-1:0];
				REG_VIEW_HEIGHT:    cfg_q.view_height    <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SOURCE_WIDTH:   prdata = DATA_W'(cfg_q.source_width);
			REG_SOURCE_HEIGHT:  prdata = DATA_W'(cfg_q.source_height);
			REG_SURFACE_WIDTH:  prdata = DATA_W'(cfg_q.surface_width);
			REG_SURFACE_HEIGHT: prdata = DATA_W'(cfg_q.surface_height);
			REG_VIEW_LEFT:      prdata = DATA_W'(cfg_q.view_left);
			REG_VIEW_TOP:       prdata = DATA_W'(cfg_q.view_top);
			REG_VIEW_WIDTH:     prdata = DATA_W'(cfg_q.view_width);
			REG_VIEW_HEIGHT:    prdata = DATA_W'(cfg_q.view_height);
			default:            prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/nnsa_front.sv */
// Front stages: geometry and request checks, viewport-local position, then the
// scale products local*frame for both axes. Depends on nnsa_pkg.
`default_nettype none
module nnsa_front
	import nnsa_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	input  wire logic [POS_W-1:0]  dest_col,
	input  wire logic [POS_W-1:0]  dest_row,
	input  wire logic [POS_W-1:0]  tile_left,
	input  wire logic [POS_W-1:0]  tile_top,
	input  wire logic [DIM_W-1:0]  tile_cols,
	input  wire logic [DIM_W-1:0]  tile_rows,
	output logic                   valid_s2,
	output side_t                  side_s2,
	output logic      [PROD_W-1:0] prod_x_s2,
	output logic      [PROD_W-1:0] prod_y_s2
);

	logic             cfg_bad, req_bad;
	logic [DIM_W:0]   view_end_x, view_end_y;
	logic [1:0]       status_c;

	logic             valid_s1;
	side_t            side_s1;
	logic [DIM_W-1:0] local_x_s1, local_y_s1;

	always_comb begin
		view_end_x = {2'b00, cfg.view_left} + {1'b0, cfg.view_width};
		view_end_y = {2'b00, cfg.view_top}  + {1'b0, cfg.view_height};
		cfg_bad = (cfg.source_width == '0) || (cfg.source_height == '0) ||
			(cfg.surface_width == '0) || (cfg.surface_height == '0) ||
			(32'(cfg.surface_width) > 32'(MAX_DIMENSION)) ||
			(32'(cfg.surface_height) > 32'(MAX_DIMENSION)) ||
			(cfg.view_width == '0) || (cfg.view_height == '0) ||
			(view_end_x > {1'b0, cfg.surface_width}) ||
			(view_end_y > {1'b0, cfg.surface_height});
		req_bad = (tile_cols == '0) || (tile_rows == '0) ||
			(({2'b00, tile_left} + {1'b0, tile_cols}) > {1'b0, cfg.source_width}) ||
			(({2'b00, tile_top} + {1'b0, tile_rows}) > {1'b0, cfg.source_height}) ||
			(dest_col < cfg.view_left) || ({2'b00, dest_col} >= view_end_x) ||
			(dest_row < cfg.view_top) || ({2'b00, dest_row} >= view_end_y);
		priority if (cfg_bad) begin
			status_c = ST_CONFIG;
		end else if (req_bad) begin
			status_c = ST_REQUEST;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.status    <= status_c;
		side_s1.tile_left <= tile_left;
		side_s1.tile_top  <= tile_top;
		side_s1.tile_cols <= tile_cols;
		side_s1.tile_rows <= tile_rows;
		local_x_s1 <= {1'b0, dest_col} - {1'b0, cfg.view_left};
		local_y_s1 <= {1'b0, dest_row} - {1'b0, cfg.view_top};
		side_s2   <= side_s1;
		prod_x_s2 <= PROD_W'(local_x_s1) * PROD_W'(cfg.source_width);
		prod_y_s2 <= PROD_W'(local_y_s1) * PROD_W'(cfg.source_height);
	end

endmodule
`default_nettype wire

/* hdl/nnsa_div_stage.sv */
// One divider stage: two restoring quotient bits per axis, registered.
// Depends on nnsa_pkg.
`default_nettype none
module nnsa_div_stage
	import nnsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              valid_in,
	input  wire side_t             side_in,
	input  wire logic [PROD_W-1:0] rx_in,
	input  wire logic [PROD_W-1:0] ry_in,
	output logic                   valid_out,
	output side_t                  side_out,
	output logic      [PROD_W-1:0] rx_out,
	output logic      [PROD_W-1:0] ry_out
);

	// upper half is the remainder, lower half shifts out dividend, in quotient
	function automatic logic [PROD_W-1:0] div_step(input logic [PROD_W-1:0] r,
		input logic [DIM_W-1:0] d);
		logic [DIM_W:0] t;
		t = r[PROD_W-1:DIM_W-1];
		if (t >= {1'b0, d}) begin
			return {DIM_W'(t - {1'b0, d}), r[DIM_W-2:0], 1'b1};
		end else begin
			return {t[DIM_W-1:0], r[DIM_W-2:0], 1'b0};
		end
	endfunction

	logic [PROD_W-1:0] rx_c, ry_c;

	always_comb begin
		rx_c = rx_in;
		ry_c = ry_in;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			rx_c = div_step(rx_c, cfg.view_width);
			ry_c = div_step(ry_c, cfg.view_height);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		side_out <= side_in;
		rx_out   <= rx_c;
		ry_out   <= ry_c;
	end

endmodule
`default_nettype wire

/* hdl/nnsa_back.sv */
// Output stage: clamp to the last frame pixel, tile bounds check, tile-local
// coordinates and the result register. Depends on nnsa_pkg.
`default_nettype none
module nnsa_back
	import nnsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              valid_in,
	input  wire side_t             side_in,
	input  wire logic [PROD_W-1:0] rx_in,
	input  wire logic [PROD_W-1:0] ry_in,
	output logic                   done,
	output logic      [POS_W-1:0]  src_local_col,
	output logic      [POS_W-1:0]  src_local_row,
	output logic      [1:0]        status
);

	logic [DIM_W-1:0] qx, qy, last_x, last_y, sx, sy, dx, dy;
	logic             outside;
	logic [1:0]       status_c;

	always_comb begin
		qx = rx_in[DIM_W-1:0];
		qy = ry_in[DIM_W-1:0];
		last_x = cfg.source_width - DIM_W'(1);
		last_y = cfg.source_height - DIM_W'(1);
		sx = (qx < last_x) ? qx : last_x;
		sy = (qy < last_y) ? qy : last_y;
		dx = sx - {1'b0, side_in.tile_left};
		dy = sy - {1'b0, side_in.tile_top};
		outside = (sx < {1'b0, side_in.tile_left}) || (dx >= side_in.tile_cols) ||
			(sy < {1'b0, side_in.tile_top}) || (dy >= side_in.tile_rows);
		priority if (side_in.status != ST_OK) begin
			status_c = side_in.status;
		end else if (outside) begin
			status_c = ST_OUTSIDE;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		status        <= status_c;
		src_local_col <= (status_c == ST_OK) ? dx[POS_W-1:0] : '0;
		src_local_row <= (status_c == ST_OK) ? dy[POS_W-1:0] : '0;
	end

endmodule
`default_nettype wire

/* hdl/nearest_neighbor_scale_address_core.sv */
// Nearest-neighbour scaler address generator, top level.
// An accepted request passes the front stages, divider pipeline and output register to its done strobe.
// Throughput: one request per cycle; busy stays low, set by the seven-stage
// two-bit-per-stage restoring divider pipeline for both axes.
// Reset: arst_n clears the configuration registers and all pipeline valids.
// Depends on nnsa_pkg, nnsa_regs, nnsa_front, nnsa_div_stage, nnsa_back.
`default_nettype none
module nearest_neighbor_scale_address_core
	import nnsa_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [POS_W-1:0]  dest_col,
	input  wire logic [POS_W-1:0]  dest_row,
	input  wire logic [POS_W-1:0]  tile_left,
	input  wire logic [POS_W-1:0]  tile_top,
	input  wire logic [DIM_W-1:0]  tile_cols,
	input  wire logic [DIM_W-1:0]  tile_rows,
	output logic                   done,
	output logic      [POS_W-1:0]  src_local_col,
	output logic      [POS_W-1:0]  src_local_row,
	output logic      [1:0]        status
);

	cfg_t              cfg;
	logic              valid_d [DIV_STAGES+1];
	side_t             side_d  [DIV_STAGES+1];
	logic [PROD_W-1:0] rx_d    [DIV_STAGES+1];
	logic [PROD_W-1:0] ry_d    [DIV_STAGES+1];

	assign busy = 1'b0;

	nnsa_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	nnsa_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_valid(start && !busy),
		.dest_col(dest_col), .dest_row(dest_row), .tile_left(tile_left),
		.tile_top(tile_top), .tile_cols(tile_cols), .tile_rows(tile_rows),
		.valid_s2(valid_d[0]), .side_s2(side_d[0]),
		.prod_x_s2(rx_d[0]), .prod_y_s2(ry_d[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		nnsa_div_stage u_stage (
			.clk(clk), .arst_n(arst_n), .cfg(cfg),
			.valid_in(valid_d[g]), .side_in(side_d[g]), .rx_in(rx_d[g]), .ry_in(ry_d[g]),
			.valid_out(valid_d[g+1]), .side_out(side_d[g+1]),
			.rx_out(rx_d[g+1]), .ry_out(ry_d[g+1])
		);
	end

	nnsa_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.valid_in(valid_d[DIV_STAGES]), .side_in(side_d[DIV_STAGES]),
		.rx_in(rx_d[DIV_STAGES]), .ry_in(ry_d[DIV_STAGES]),
		.done(done), .src_local_col(src_local_col), .src_local_row(src_local_row),
		.status(status)
	);

endmodule
`default_nettype wire

/* hdl/nnsa_checker.sv */
// Port-level checker for the scaler address generator, bound to the top level.
// Depends on nnsa_pkg.
`default_nettype none
module nnsa_checker
	import nnsa_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire logic [POS_W-1:0] src_local_col,
	input wire logic [POS_W-1:0] src_local_row,
	input wire logic [1:0]       status
);

	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LATENCY done)
		else $error("request without done");

	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("done without request");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (src_local_col == '0 && src_local_row == '0))
		else $error("nonzero coordinates with error status");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind nearest_neighbor_scale_address_core nnsa_checker u_nnsa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.src_local_col(src_local_col), .src_local_row(src_local_row), .status(status)
);
`default_nettype wire

/* verif/nearest_neighbor_scale_address_core_test.sv */
// Self-checking testbench for the nearest-neighbour scaler address generator.
// Drives requests and APB register writes, predicts each result and compares it.
// Depends on nnsa_pkg and nearest_neighbor_scale_address_core.
`timescale 1ns / 1ps
module nearest_neighbor_scale_address_core_test;
	import nnsa_pkg::*;

	typedef struct {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [1:0]       st;
	} addr_result_t;

	typedef struct {
		logic [POS_W-1:0] dcol, drow, tleft, ttop;
		logic [DIM_W-1:0] tcols, trows;
		bit               fixed;
		logic [1:0]       st;
	} request_row_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start = 0;
	logic              busy;
	logic [POS_W-1:0]  dest_col = '0, dest_row = '0, tile_left = '0, tile_top = '0;
	logic [DIM_W-1:0]  tile_cols = '0, tile_rows = '0;
	logic              done;
	logic [POS_W-1:0]  src_local_col, src_local_row;
	logic [1:0]        status;

	nearest_neighbor_scale_address_core dut (.*);

	always #5 clk = ~clk;

	cfg_t         geom;
	addr_result_t pending_addrs[$];
	int           mismatches = 0;
	int           requests_sent = 0;
	int           results_seen = 0;
	int           status_seen[4] = '{0, 0, 0, 0};
	longint       cycles = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	function automatic logic [DIM_W-1:0] scale_axis(input int unsigned loc, input int unsigned frame,
			input int unsigned view);
		longint unsigned q;
		q = (longint'(loc) * frame) / view;
		return DIM_W'((q < frame - 1) ? q : frame - 1);
	endfunction

	function automatic addr_result_t predict_addr(input request_row_t r);
		addr_result_t res;
		int unsigned sx, sy;
		res = '{0, 0, ST_OK};
		if (geom.source_width == 0 || geom.source_height == 0 || geom.surface_width == 0
				|| geom.surface_height == 0 || geom.surface_width > MAX_DIMENSION_DEF
				|| geom.surface_height > MAX_DIMENSION_DEF || geom.view_width == 0
				|| geom.view_height == 0
				|| 32'(geom.view_left) + geom.view_width > geom.surface_width
				|| 32'(geom.view_top) + geom.view_height > geom.surface_height) begin
			res.st = ST_CONFIG;
		end else if (r.tcols == 0 || r.trows == 0
				|| 32'(r.tleft) + r.tcols > geom.source_width
				|| 32'(r.ttop) + r.trows > geom.source_height
				|| r.dcol < geom.view_left || 32'(r.dcol) >= 32'(geom.view_left) + geom.view_width
				|| r.drow < geom.view_top || 32'(r.drow) >= 32'(geom.view_top) + geom.view_height) begin
			res.st = ST_REQUEST;
		end else begin
			sx = scale_axis(r.dcol - geom.view_left, geom.source_width, geom.view_width);
			sy = scale_axis(r.drow - geom.view_top, geom.source_height, geom.view_height);
			if (sx < r.tleft || sx - r.tleft >= r.tcols || sy < r.ttop || sy - r.ttop >= r.trows)
				res.st = ST_OUTSIDE;
			else begin
				res.col = POS_W'(sx - r.tleft);
				res.row = POS_W'(sy - r.ttop);
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Timeout with %0d results outstanding", pending_addrs.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		addr_result_t want;
		if (arst_n && done) begin
			if (pending_addrs.size() == 0) begin
				report_mismatch("unexpected result", status, -1);
			end else begin
				want = pending_addrs.pop_front();
				results_seen++;
				status_seen[status]++;
				if (status !== want.st) report_mismatch("status", status, want.st);
				if (src_local_col !== want.col) report_mismatch("src_local_col", src_local_col, want.col);
				if (src_local_row !== want.row) report_mismatch("src_local_row", src_local_row, want.row);
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input int unsigned value);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(idx) << 2; pwdata <= value;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_SOURCE_WIDTH:   geom.source_width = DIM_W'(value);
			REG_SOURCE_HEIGHT:  geom.source_height = DIM_W'(value);
			REG_SURFACE_WIDTH:  geom.surface_width = DIM_W'(value);
			REG_SURFACE_HEIGHT: geom.surface_height = DIM_W'(value);
			REG_VIEW_LEFT:      geom.view_left = POS_W'(value);
			REG_VIEW_TOP:       geom.view_top = POS_W'(value);
			REG_VIEW_WIDTH:     geom.view_width = DIM_W'(value);
			default:            geom.view_height = DIM_W'(value);
		endcase
	endtask

	task automatic set_geometry(input int unsigned sw, sh, fw, fh, vl, vt, vw, vh);
		write_reg(REG_SOURCE_WIDTH, sw);
		write_reg(REG_SOURCE_HEIGHT, sh);
		write_reg(REG_SURFACE_WIDTH, fw);
		write_reg(REG_SURFACE_HEIGHT, fh);
		write_reg(REG_VIEW_LEFT, vl);
		write_reg(REG_VIEW_TOP, vt);
		write_reg(REG_VIEW_WIDTH, vw);
		write_reg(REG_VIEW_HEIGHT, vh);
	endtask

	// drain, then wait out the pipeline before touching registers
	task automatic drain;
		while (pending_addrs.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_request(input request_row_t r);
		addr_result_t want;
		dest_col <= r.dcol; dest_row <= r.drow; tile_left <= r.tleft; tile_top <= r.ttop;
		tile_cols <= r.tcols; tile_rows <= r.trows;
		start <= 1;
		do @(posedge clk); while (busy);
		want = predict_addr(r);
		if (r.fixed && want.st !== r.st) report_mismatch("table status", want.st, r.st);
		pending_addrs.push_back(want);
		requests_sent++;
	endtask

	function automatic request_row_t random_request(input int mode);
		request_row_t r;
		int unsigned vw, vh;
		r.fixed = 0;
		r.st = ST_OK;
		if (mode < 7 && geom.view_width != 0 && geom.view_height != 0
				&& geom.source_width != 0 && geom.source_height != 0) begin
			vw = geom.view_width; vh = geom.view_height;
			r.dcol = POS_W'(geom.view_left + $urandom_range(vw - 1, 0));
			r.drow = POS_W'(geom.view_top + $urandom_range(vh - 1, 0));
			r.tleft = POS_W'($urandom_range(geom.source_width - 1, 0));
			r.ttop = POS_W'($urandom_range(geom.source_height - 1, 0));
			r.tcols = DIM_W'($urandom_range(geom.source_width - r.tleft, 1));
			r.trows = DIM_W'($urandom_range(geom.source_height - r.ttop, 1));
			if (mode < 3) begin
				r.tleft = 0; r.ttop = 0;
				r.tcols = geom.source_width; r.trows = geom.source_height;
			end
		end else begin
			r.dcol = POS_W'($urandom); r.drow = POS_W'($urandom);
			r.tleft = POS_W'($urandom); r.ttop = POS_W'($urandom);
			r.tcols = DIM_W'($urandom); r.trows = DIM_W'($urandom);
		end
		return r;
	endfunction

	task automatic random_phase(input int count);
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(12, 1);
			repeat (burst) begin
				send_request(random_request($urandom_range(9, 0)));
				sent++;
			end
			if ($urandom_range(3, 0) != 0) begin
				start <= 0;
				repeat ($urandom_range(5, 1)) @(posedge clk);
			end
		end
		start <= 0;
		drain();
	endtask

	request_row_t directed_rows[$];

	initial begin
		int unsigned sizes[6][8];
		arst_n = 0;
		geom = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// unconfigured after reset
		directed_rows.push_back('{0, 0, 0, 0, 1, 1, 1, ST_CONFIG});
		directed_rows.push_back('{8191, 8191, 8191, 8191, 8192, 8192, 1, ST_CONFIG});
		foreach (directed_rows[i]) send_request(directed_rows[i]);
		start <= 0;
		drain();

		set_geometry(100, 60, 640, 480, 20, 10, 200, 120);
		directed_rows = {};
		directed_rows.push_back('{20, 10, 0, 0, 100, 60, 1, ST_OK});
		directed_rows.push_back('{219, 129, 0, 0, 100, 60, 0, ST_OK});
		directed_rows.push_back('{19, 10, 0, 0, 100, 60, 1, ST_REQUEST});
		directed_rows.push_back('{220, 10, 0, 0, 100, 60, 1, ST_REQUEST});
		directed_rows.push_back('{20, 9, 0, 0, 100, 60, 1, ST_REQUEST});
		directed_rows.push_back('{20, 130, 0, 0, 100, 60, 1, ST_REQUEST});
		directed_rows.push_back('{20, 10, 0, 0, 0, 60, 1, ST_REQUEST});
		directed_rows.push_back('{20, 10, 0, 0, 100, 0, 1, ST_REQUEST});
		directed_rows.push_back('{20, 10, 1, 0, 100, 60, 1, ST_REQUEST});
		directed_rows.push_back('{20, 10, 0, 1, 100, 60, 1, ST_REQUEST});
		directed_rows.push_back('{20, 10, 50, 0, 50, 60, 1, ST_OUTSIDE});
		directed_rows.push_back('{219, 10, 0, 0, 50, 60, 1, ST_OUTSIDE});
		directed_rows.push_back('{120, 70, 50, 30, 50, 30, 0, ST_OK});
		directed_rows.push_back('{8191, 8191, 8191, 8191, 16383, 16383, 1, ST_REQUEST});
		foreach (directed_rows[i]) send_request(directed_rows[i]);
		start <= 0;
		drain();

		// extremes, oversized and invalid geometries; then a sweep of random ones
		sizes = '{'{8192, 8192, 8192, 8192, 0, 0, 8192, 8192},
			'{1, 1, 8192, 8192, 8191, 8191, 1, 1},
			'{8192, 8192, 16383, 8192, 0, 0, 64, 64},
			'{16383, 16383, 8192, 8192, 4096, 0, 4096, 8192},
			'{7, 5, 16, 16, 3, 3, 13, 11},
			'{8192, 1, 8192, 8192, 1, 1, 8192, 8191}};
		foreach (sizes[i]) begin
			set_geometry(sizes[i][0], sizes[i][1], sizes[i][2], sizes[i][3],
				sizes[i][4], sizes[i][5], sizes[i][6], sizes[i][7]);
			random_phase(40);
		end
		repeat (16) begin
			int unsigned fw, fh, vw, vh;
			fw = $urandom_range(8192, 1); fh = $urandom_range(8192, 1);
			vw = $urandom_range(fw, 1); vh = $urandom_range(fh, 1);
			set_geometry($urandom_range(8192, 1), $urandom_range(8192, 1), fw, fh,
				$urandom_range(fw - vw, 0), $urandom_range(fh - vh, 0), vw, vh);
			random_phase(106);
		end

		drain();
		$display("Sent %0d requests, checked %0d results", requests_sent, results_seen);
		$display("Status mix ok/config/request/outside: %0d/%0d/%0d/%0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0 && pending_addrs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
